FILE: design/fpalu_pkg.sv
// Package: widths, operation and status codes, and divider stage type of the fixed-point ALU.
`default_nettype none

package fpalu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DIV_STEPS = DIV_W;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OVF  = 2'd1,
      STATUS_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              div0;
      logic              neg;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] res;
      status_type        st;
      logic [DATA_W-1:0] rem;
      logic [DIV_W-1:0]  dq;
      logic [DATA_W-1:0] den;
   } stage_type;

endpackage

`default_nettype wire

FILE: design/fixed_point_alu_with_overflow.sv
// Top level: pipelined signed fixed-point add, subtract, multiply and divide with overflow status.
// Registers in order: input stage, operand stage, the stage registers of the restoring divider,
// which resolves one quotient bit per pipeline stage, then the result register behind rsp_valid.
// Throughput: one item per cycle for every operation; busy stays low.
// Reset clears all valid bits; payload registers are not reset.
// Results leave on a one-cycle rsp_valid strobe; the receiver cannot stall.
`default_nettype none

module fixed_point_alu_with_overflow (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_mode,
   input  wire logic signed [fpalu_pkg::DATA_W-1:0] req_operand_a,
   input  wire logic signed [fpalu_pkg::DATA_W-1:0] req_operand_b,
   output logic                                   rsp_valid,
   output logic signed [fpalu_pkg::DATA_W-1:0]    rsp_result_value,
   output logic [1:0]                             rsp_status
);
   import fpalu_pkg::*;

   localparam logic [DIV_W-1:0] QLIM = DIV_W'(64'h0000_0000_8000_0000);

   // input stage
   logic                     a_valid_ff;
   mode_type                 a_mode_ff;
   logic signed [DATA_W-1:0] a_opa_ff;
   logic signed [DATA_W-1:0] a_opb_ff;

   // operand stage
   logic                     b_valid_ff;
   mode_type                 b_mode_ff;
   logic [DATA_W-1:0]        b_opa_ff;
   logic [DATA_W:0]          b_sum_ff;
   logic signed [63:0]       b_prod_ff;
   logic [DIV_W-1:0]         b_num_ff;
   logic [DATA_W-1:0]        b_den_ff;
   logic                     b_neg_ff;
   logic                     b_div0_ff;

   logic [DATA_W:0]          b_sum_in;
   logic signed [63:0]       b_prod_in;
   logic [DATA_W-1:0]        abs_a;
   logic [DATA_W-1:0]        abs_b;

   stage_type                stage_ff [0:DIV_STEPS];
   stage_type                stage_in [0:DIV_STEPS];

   logic signed [63:0]       prod_shift;
   logic                     mul_fits;
   logic                     sum_fits;

   logic [DIV_W-1:0]         quo;
   logic [DATA_W-1:0]        quo_signed;
   logic                     quo_fits;

   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   status_type               rsp_status_ff;
   logic [DATA_W-1:0]        rsp_value_in;
   status_type               rsp_status_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
      end
      a_mode_ff <= mode_type'(req_mode);
      a_opa_ff  <= req_operand_a;
      a_opb_ff  <= req_operand_b;
   end

   assign abs_a     = a_opa_ff[DATA_W-1] ? (~a_opa_ff + DATA_W'(1)) : a_opa_ff;
   assign abs_b     = a_opb_ff[DATA_W-1] ? (~a_opb_ff + DATA_W'(1)) : a_opb_ff;
   assign b_prod_in = 64'(a_opa_ff) * 64'(a_opb_ff);

   always_comb begin
      if (a_mode_ff == MODE_SUB) begin
         b_sum_in = {a_opa_ff[DATA_W-1], a_opa_ff} - {a_opb_ff[DATA_W-1], a_opb_ff};
      end else begin
         b_sum_in = {a_opa_ff[DATA_W-1], a_opa_ff} + {a_opb_ff[DATA_W-1], a_opb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_mode_ff <= a_mode_ff;
      b_opa_ff  <= a_opa_ff;
      b_sum_ff  <= b_sum_in;
      b_prod_ff <= b_prod_in;
      b_num_ff  <= DIV_W'(abs_a) << FRAC_BITS;
      b_den_ff  <= abs_b;
      b_neg_ff  <= a_opa_ff[DATA_W-1] ^ a_opb_ff[DATA_W-1];
      b_div0_ff <= (a_opb_ff == '0);
   end

   assign prod_shift = b_prod_ff >>> FRAC_BITS;
   assign mul_fits   = (prod_shift[63:DATA_W-1] == {(65-DATA_W){prod_shift[DATA_W-1]}});
   assign sum_fits   = (b_sum_ff[DATA_W] == b_sum_ff[DATA_W-1]);

   always_comb begin
      stage_in[0].valid  = b_valid_ff;
      stage_in[0].is_div = (b_mode_ff == MODE_DIV);
      stage_in[0].div0   = b_div0_ff;
      stage_in[0].neg    = b_neg_ff;
      stage_in[0].a      = b_opa_ff;
      stage_in[0].rem    = '0;
      stage_in[0].dq     = b_num_ff;
      stage_in[0].den    = b_den_ff;
      stage_in[0].res    = b_opa_ff;
      stage_in[0].st     = STATUS_OK;
      unique case (b_mode_ff)
         MODE_ADD, MODE_SUB: begin
            if (sum_fits) begin
               stage_in[0].res = b_sum_ff[DATA_W-1:0];
            end else begin
               stage_in[0].st  = STATUS_OVF;
            end
         end
         MODE_MUL: begin
            if (mul_fits) begin
               stage_in[0].res = prod_shift[DATA_W-1:0];
            end else begin
               stage_in[0].st  = STATUS_OVF;
            end
         end
         MODE_DIV: begin
            if (b_div0_ff) begin
               stage_in[0].st = STATUS_DIV0;
            end
         end
         default: begin
            stage_in[0].st = STATUS_OK;
         end
      endcase
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [DATA_W:0] rem_sh;
      logic [DATA_W:0] diff;

      assign rem_sh = {stage_ff[k].rem, stage_ff[k].dq[DIV_W-1]};
      assign diff   = rem_sh - {1'b0, stage_ff[k].den};

      always_comb begin
         stage_in[k+1] = stage_ff[k];
         if (diff[DATA_W]) begin
            stage_in[k+1].rem = rem_sh[DATA_W-1:0];
            stage_in[k+1].dq  = {stage_ff[k].dq[DIV_W-2:0], 1'b0};
         end else begin
            stage_in[k+1].rem = diff[DATA_W-1:0];
            stage_in[k+1].dq  = {stage_ff[k].dq[DIV_W-2:0], 1'b1};
         end
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign quo        = stage_ff[DIV_STEPS].dq;
   assign quo_fits   = stage_ff[DIV_STEPS].neg ? (quo <= QLIM) : (quo < QLIM);
   assign quo_signed = stage_ff[DIV_STEPS].neg ? (~quo[DATA_W-1:0] + DATA_W'(1))
                                               : quo[DATA_W-1:0];

   always_comb begin
      rsp_value_in  = stage_ff[DIV_STEPS].res;
      rsp_status_in = stage_ff[DIV_STEPS].st;
      if (stage_ff[DIV_STEPS].is_div && !stage_ff[DIV_STEPS].div0) begin
         if (quo_fits) begin
            rsp_value_in  = quo_signed;
         end else begin
            rsp_value_in  = stage_ff[DIV_STEPS].a;
            rsp_status_in = STATUS_OVF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_ff[DIV_STEPS].valid;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

FILE: tb/sv/fpalu_checker.sv
// Checker for the fixed-point ALU: predicts each accepted item and compares every result.
module fpalu_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic signed [fpalu_pkg::DATA_W-1:0] req_operand_a,
   input  wire logic signed [fpalu_pkg::DATA_W-1:0] req_operand_b,
   input  wire logic                                rsp_valid,
   input  wire logic signed [fpalu_pkg::DATA_W-1:0] rsp_result_value,
   input  wire logic [1:0]                          rsp_status,
   output int                                       fail_count,
   output int                                       outstanding,
   output int                                       ok_count,
   output int                                       ovf_count,
   output int                                       div0_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpalu_pkg::*;

   localparam longint LARGEST_VALUE  = 64'sd2147483647;
   localparam longint SMALLEST_VALUE = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      status_type               status;
   } alu_result_type;

   alu_result_type pending_results[$];

   function automatic alu_result_type compute_alu_result(
      input mode_type                 op,
      input logic signed [DATA_W-1:0] lhs,
      input logic signed [DATA_W-1:0] rhs
   );
      longint wide_lhs;
      longint wide_rhs;
      longint exact;
      alu_result_type r;
      wide_lhs = lhs;
      wide_rhs = rhs;
      exact    = 0;
      r.status = STATUS_OK;
      case (op)
         MODE_ADD: exact = wide_lhs + wide_rhs;
         MODE_SUB: exact = wide_lhs - wide_rhs;
         MODE_MUL: exact = (wide_lhs * wide_rhs) >>> FRAC_BITS;
         default: begin
            if (wide_rhs == 0) begin
               r.status = STATUS_DIV0;
            end else begin
               exact = (wide_lhs <<< FRAC_BITS) / wide_rhs;
            end
         end
      endcase
      if (r.status == STATUS_OK && (exact > LARGEST_VALUE || exact < SMALLEST_VALUE)) begin
         r.status = STATUS_OVF;
      end
      r.value = (r.status == STATUS_OK) ? exact[DATA_W-1:0] : lhs;
      return r;
   endfunction

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_results.push_back(compute_alu_result(mode_type'(req_mode),
                                                         req_operand_a, req_operand_b));
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with no item pending: value %0d, status %0d",
                      rsp_result_value, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_results.pop_front();
               case (want.status)
                  STATUS_OK:  ok_count   <= ok_count + 1;
                  STATUS_OVF: ovf_count  <= ovf_count + 1;
                  default:    div0_count <= div0_count + 1;
               endcase
               if (rsp_result_value !== want.value || rsp_status !== want.status) begin
                  if (rsp_result_value !== want.value) begin
                     $error("result_value: expected %0d, actual %0d",
                            want.value, rsp_result_value);
                  end
                  if (rsp_status !== want.status) begin
                     $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: clock, reset and item stimulus for the fixed-point ALU, plus the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fpalu_pkg::*;

   localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ONE_FIX  = 32'sd1 <<< FRAC_BITS;
   localparam int RANDOM_PER_PHASE = 660;
   localparam int DRAIN_CYCLES     = 60;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_mode;
   logic signed [DATA_W-1:0] req_operand_a;
   logic signed [DATA_W-1:0] req_operand_b;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [1:0]               rsp_status;

   int fail_count;
   int outstanding;
   int ok_count;
   int ovf_count;
   int div0_count;
   int items_sent;
   int gap_pct;

   int phase_gaps[3] = '{0, 81, 24};

   fixed_point_alu_with_overflow dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   fpalu_checker result_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .ok_count         (ok_count),
      .ovf_count        (ovf_count),
      .div0_count       (div0_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic signed [DATA_W-1:0] pick_operand();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 8191) - 4096;
         1: v = $urandom_range(0, 2097151) - 1048576;
         2: begin
            case ($urandom_range(0, 5))
               0:       v = MOST_POS;
               1:       v = MOST_NEG;
               2:       v = 0;
               3:       v = -1;
               4:       v = 1;
               default: v = ONE_FIX;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_item(input mode_type op, input logic signed [DATA_W-1:0] lhs,
                            input logic signed [DATA_W-1:0] rhs);
      while ($urandom_range(0, 99) < gap_pct) begin
         start         <= 1'b0;
         req_mode      <= 2'($urandom_range(0, 3));
         req_operand_a <= $urandom;
         req_operand_b <= $urandom;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_mode      <= op;
      req_operand_a <= lhs;
      req_operand_b <= rhs;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_mode      = MODE_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      gap_pct       = 0;
      items_sent    = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(MODE_ADD, MOST_POS, 1);
      send_item(MODE_ADD, MOST_NEG, -1);
      send_item(MODE_ADD, MOST_POS, MOST_NEG);
      send_item(MODE_SUB, MOST_NEG, 1);
      send_item(MODE_SUB, MOST_POS, -1);
      send_item(MODE_SUB, 0, MOST_NEG);
      send_item(MODE_SUB, -1, MOST_POS);
      send_item(MODE_MUL, ONE_FIX, ONE_FIX);
      send_item(MODE_MUL, -1, 1);
      send_item(MODE_MUL, -257, 1);
      send_item(MODE_MUL, MOST_NEG, MOST_NEG);
      send_item(MODE_MUL, MOST_POS, ONE_FIX);
      send_item(MODE_MUL, MOST_POS, ONE_FIX + 1);
      send_item(MODE_MUL, MOST_NEG, -ONE_FIX);
      send_item(MODE_DIV, ONE_FIX, 0);
      send_item(MODE_DIV, 0, 0);
      send_item(MODE_DIV, MOST_NEG, -1);
      send_item(MODE_DIV, -1, 3);
      send_item(MODE_DIV, MOST_NEG, MOST_NEG);
      send_item(MODE_DIV, 1, MOST_POS);
      send_item(MODE_DIV, MOST_POS, ONE_FIX);
      send_item(MODE_DIV, MOST_POS, 1);

      foreach (phase_gaps[p]) begin
         gap_pct = phase_gaps[p];
         repeat (RANDOM_PER_PHASE) begin
            send_item(mode_type'($urandom_range(0, 3)), pick_operand(), pick_operand());
         end
      end
      start <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items of all four operations with 0, 81 and 24 percent sender gaps",
               items_sent);
      $display("Results checked: %0d ok, %0d overflow, %0d divide by zero",
               ok_count, ovf_count, div0_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
